// ----- rtl/digest_bloom_filter_defines.svh -----
`ifndef DIGEST_BLOOM_FILTER_DEFINES_SVH
`define DIGEST_BLOOM_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DBF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bloom filter check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bloom filter check failed");

`endif

// ----- rtl/dbf_pkg.sv -----
`default_nettype none

package dbf_pkg;

    // Digest layout and index arithmetic.
    localparam int NUM_WORDS     = 8;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 17;
    localparam int CNT_W         = 4;
    localparam int PTR_W         = 3;
    localparam int BITS_PER_STEP = 4;
    localparam int MOD_STEPS     = WORD_W / BITS_PER_STEP;
    localparam int STEP_W        = 3;
    localparam int ROW_W         = 8;
    localparam int ROW_SEL_W     = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 1'b1;
    localparam logic [CNT_W-1:0] HASH_COUNT_RST = 4'd1;
    localparam logic [IDX_W-1:0] MODULUS_RST    = 17'd65536;

    // Command codes.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_CHECK
    } state_t;

    // Request into the shared modulo unit.
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [IDX_W-1:0]  divisor;
    } mod_req_t;

    // Response from the shared modulo unit.
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] remainder;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/dbf_mod_unit.sv -----
`default_nettype none

module dbf_mod_unit (
    input  wire               clk,
    input  wire               rst_n,
    input  dbf_pkg::mod_req_t req,
    output dbf_pkg::mod_rsp_t rsp
);
    import dbf_pkg::*;

    logic                active_reg, active_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic [IDX_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    div_reg, div_next;
    logic [IDX_W:0]      trial;
    logic [IDX_W-1:0]    rem_step;

    // Restoring remainder, four dividend bits per cycle, most significant first.
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            trial = {rem_step, shift_reg[WORD_W-1-k]};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_step = trial[IDX_W-1:0];
        end
    end

    // Sequencing of the digit steps.
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            shift_next  = req.dividend;
            rem_next    = '0;
            div_next    = req.divisor;
        end
        else if (active_reg)
        begin
            shift_next = shift_reg << BITS_PER_STEP;
            rem_next   = rem_step;
            step_next  = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(MOD_STEPS - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    // A zero modulus maps every word to index zero.
    assign rsp.done      = done_reg;
    assign rsp.remainder = (div_reg == '0) ? '0 : rem_reg;

endmodule

`default_nettype wire

// ----- rtl/digest_bloom_filter.sv -----
`default_nettype none

// Bloom filter keyed by a 256-bit digest given as eight 32-bit words.
// Command channel: a command and digest are taken at a rising edge with start
// high and busy low. Command add sets one filter bit per used word; command
// query answers on might_contain, marked by a one-cycle done strobe.
// Each of the first hash_count words (clamped to eight) selects bit
// (word mod modulus); bits at or above MAX_BITS are ignored by add and
// read as clear by query. A query stops at the first clear bit.
// Timing: each used word passes through the shared four-bit-per-cycle
// modulo unit, then the single store port (a read and, for add, a write);
// busy is held for the whole item and a query's done rises as busy falls.
// A query with hash_count zero answers 1 in the cycle after it is taken.
// Results cannot be stalled; done is high for exactly one cycle per query.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong in idle periods only.
// Reset: after rst_n rises the store is swept clear one byte row per cycle,
// all (MAX_BITS + 7) / 8 rows, with busy high; configuration returns to
// hash_count 1 and modulus 65536.
module digest_bloom_filter #(
    parameter int MAX_BITS = 65536
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               command,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_0,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_1,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_2,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_3,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_4,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_5,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_6,
    input  wire  [dbf_pkg::WORD_W-1:0]        digest_word_7,
    output logic                              done,
    output logic                              might_contain,
    input  wire                               cfg_write,
    input  wire  [dbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [dbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dbf_pkg::*;

    localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
    localparam int AW   = $clog2(ROWS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  hash_count_reg;
    logic [IDX_W-1:0]  modulus_reg;
    logic              cmd_reg;
    logic [WORD_W-1:0] dig_reg [NUM_WORDS];
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [AW-1:0]     clr_reg;
    logic [ROW_SEL_W-1:0] bit_reg;
    logic              in_range_reg;
    logic [AW-1:0]     addr_reg;
    logic [ROW_W-1:0]  rdata_reg;
    logic              done_reg, done_next;
    logic              might_reg, might_next;

    logic [ROW_W-1:0]  mem [ROWS];

    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    logic              accept;
    logic [CNT_W-1:0]  count_in;
    logic [WORD_W-1:0] idx_full;
    logic              in_range_now;
    logic              bit_ok;
    logic              is_last;
    logic              finish;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [ROW_W-1:0]  mem_wdata;
    logic              capture;
    logic              advance;

    dbf_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Shared status terms.
    assign accept       = start && (state_reg == ST_IDLE);
    assign count_in     = (hash_count_reg > CNT_W'(NUM_WORDS)) ? CNT_W'(NUM_WORDS)
                                                               : hash_count_reg;
    assign idx_full     = WORD_W'(mod_rsp.remainder);
    assign in_range_now = idx_full < WORD_W'(MAX_BITS);
    assign bit_ok       = in_range_reg && rdata_reg[bit_reg];
    assign is_last      = (CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg;
    assign finish       = ((cmd_reg == CMD_QUERY) && !bit_ok) || is_last;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (count_in != '0))
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = finish ? ST_IDLE : ST_MOD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control for each state.
    always_comb
    begin
        mod_req    = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = addr_reg;
        mem_wdata  = '0;
        done_next  = 1'b0;
        might_next = might_reg;
        capture    = 1'b0;
        advance    = 1'b0;
        mod_req.divisor = modulus_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_in == '0)
                    begin
                        done_next  = (command == CMD_QUERY);
                        might_next = (command == CMD_QUERY) ? 1'b1 : might_reg;
                    end
                    else
                    begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = digest_word_0;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_rsp.done)
                begin
                    mem_re   = in_range_now;
                    mem_addr = AW'(idx_full >> ROW_SEL_W);
                    capture  = 1'b1;
                end
            end
            ST_CHECK:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    mem_we    = in_range_reg;
                    mem_wdata = rdata_reg | (ROW_W'(1) << bit_reg);
                end
                if (finish)
                begin
                    done_next  = (cmd_reg == CMD_QUERY);
                    might_next = (cmd_reg == CMD_QUERY) ? bit_ok : might_reg;
                end
                else
                begin
                    mod_req.start    = 1'b1;
                    mod_req.dividend = dig_reg[ptr_reg + PTR_W'(1)];
                    advance          = 1'b1;
                end
            end
            default:
            begin
                mod_req = '0;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            ptr_reg        <= '0;
            done_reg       <= 1'b0;
            might_reg      <= 1'b0;
            hash_count_reg <= HASH_COUNT_RST;
            modulus_reg    <= MODULUS_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            might_reg <= might_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (accept)
            begin
                ptr_reg <= '0;
            end
            else if (advance)
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_HASH_COUNT: hash_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_MODULUS:    modulus_reg    <= cfg_data[IDX_W-1:0];
                    default:        hash_count_reg <= hash_count_reg;
                endcase
            end
        end
    end

    // Item payload and per-word index fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            count_reg  <= count_in;
            dig_reg[0] <= digest_word_0;
            dig_reg[1] <= digest_word_1;
            dig_reg[2] <= digest_word_2;
            dig_reg[3] <= digest_word_3;
            dig_reg[4] <= digest_word_4;
            dig_reg[5] <= digest_word_5;
            dig_reg[6] <= digest_word_6;
            dig_reg[7] <= digest_word_7;
        end
        if (capture)
        begin
            bit_reg      <= idx_full[ROW_SEL_W-1:0];
            in_range_reg <= in_range_now;
            addr_reg     <= AW'(idx_full >> ROW_SEL_W);
        end
    end

    // Filter store: one byte row per address, one access per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign might_contain = might_reg;

endmodule

`default_nettype wire

// ----- rtl/dbf_checker.sv -----
`default_nettype none

`include "digest_bloom_filter_defines.svh"

module dbf_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire done,
    input wire might_contain
);
    // A result is only shown once the block has returned to idle.
    `DBF_ASSERT_SAME(a_done_idle, done, !busy)

    // A result follows either a finished item or an item just taken.
    `DBF_ASSERT_SAME(a_done_cause, done, $past(busy) || $past(start))

    // The block only becomes busy by taking an item.
    `DBF_ASSERT_NEXT(a_busy_cause, !busy && !start, !busy)

    // The answer changes only together with its strobe.
    `DBF_ASSERT_SAME(a_answer_hold, !done, $stable(might_contain))

endmodule

bind digest_bloom_filter dbf_checker u_dbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .might_contain (might_contain)
);

`default_nettype wire
